>>> rtl/frr_pkg.sv
// Package: word types, phase and status codes for the framed response receiver.
`timescale 1ns / 1ps
`default_nettype none
package frr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HEAD  = 3'd1,
    PH_SIZE  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_DECODING = 3'd1,
    ST_ERROR    = 3'd2,
    ST_READY    = 3'd3,
    ST_NACK     = 3'd4,
    ST_MISSING  = 3'd5,
    ST_WRONG    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_HEAD_MARKER   = 2'd0,
    REG_SIZE_LIMIT    = 2'd1,
    REG_NACK_MASK     = 2'd2,
    REG_TIMEOUT_TICKS = 2'd3
  } reg_index_t;

  localparam logic [7:0]  HEAD_MARKER_RST   = 8'd126;
  localparam logic [7:0]  SIZE_LIMIT_RST    = 8'd64;
  localparam logic [7:0]  NACK_MASK_RST     = 8'd128;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd5000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    status_t    status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } out_word_t;

endpackage
`default_nettype wire

>>> rtl/framed_response_receiver_top.sv
// Top level: framed response receiver with frame decode, XOR check and timeout.
`timescale 1ns / 1ps
`default_nettype none
// Each input word is a received byte, a request-sent event or a timer tick, and
// yields exactly one result word. A word is captured into an input register and
// decoded against the frame state while held there, once the output register
// is free or being drained; the block sustains one word per cycle while out_ready
// stays high, and each result is registered into out_data.
// Configuration writes land immediately and are meant for idle periods.
module framed_response_receiver_top
  import frr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration
  logic [7:0]  head_marker;
  logic [7:0]  size_limit;
  logic [7:0]  nack_mask;
  logic [15:0] timeout_ticks;

  // frame state
  phase_t      phase, phase_next;
  logic [7:0]  frame_size, frame_size_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  first_payload, first_payload_next;
  logic [15:0] timer_left, timer_left_next;

  // input register
  logic        in_held;
  in_word_t    in_q;

  logic        advance;
  out_word_t   res;
  logic [7:0]  count_inc;

  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_marker   <= HEAD_MARKER_RST;
      size_limit    <= SIZE_LIMIT_RST;
      nack_mask     <= NACK_MASK_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_HEAD_MARKER:   head_marker   <= cfg_data[7:0];
        REG_SIZE_LIMIT:    size_limit    <= cfg_data[7:0];
        REG_NACK_MASK:     nack_mask     <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  assign count_inc = byte_count + 8'd1;

  always_comb begin
    phase_next         = phase;
    frame_size_next    = frame_size;
    byte_count_next    = byte_count;
    running_xor_next   = running_xor;
    first_payload_next = first_payload;
    timer_left_next    = timer_left;
    res                = '0;
    res.status         = ST_NONE;
    unique case (kind_t'(in_q.kind))
      KIND_BYTE: begin
        unique case (phase)
          PH_HEAD: begin
            if (in_q.rx_byte != head_marker) begin
              res.status = ST_ERROR;
            end else begin
              res.status = ST_DECODING;
              phase_next = PH_SIZE;
            end
          end
          PH_SIZE: begin
            if (in_q.rx_byte >= size_limit) begin
              res.status = ST_ERROR;
            end else begin
              res.status         = ST_DECODING;
              frame_size_next    = in_q.rx_byte;
              byte_count_next    = '0;
              running_xor_next   = in_q.rx_byte;
              first_payload_next = '0;
              phase_next         = (in_q.rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            res.status        = ST_DECODING;
            res.payload_valid = 1'b1;
            res.payload_byte  = in_q.rx_byte;
            res.payload_index = byte_count;
            if (byte_count == 8'd0) begin
              first_payload_next = in_q.rx_byte;
            end
            running_xor_next = running_xor ^ in_q.rx_byte;
            byte_count_next  = count_inc;
            if (count_inc >= frame_size) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            priority if (in_q.rx_byte != running_xor) begin
              res.status = ST_ERROR;
            end else if ((first_payload & nack_mask) != 8'd0) begin
              // hold in checksum phase until the timer runs out
              res.status = ST_NACK;
            end else begin
              res.status      = ST_READY;
              phase_next      = PH_IDLE;
              timer_left_next = '0;
            end
          end
          default: res.status = ST_ERROR;
        endcase
      end
      KIND_ARM: begin
        phase_next      = PH_HEAD;
        timer_left_next = timeout_ticks;
      end
      KIND_TICK: begin
        if (phase != PH_IDLE) begin
          if (timer_left <= 16'd1) begin
            res.status      = (phase == PH_HEAD) ? ST_MISSING : ST_WRONG;
            phase_next      = PH_IDLE;
            timer_left_next = '0;
          end else begin
            timer_left_next = timer_left - 16'd1;
          end
        end
      end
      KIND_UNUSED: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_size    <= '0;
      byte_count    <= '0;
      running_xor   <= '0;
      first_payload <= '0;
      timer_left    <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      frame_size    <= frame_size_next;
      byte_count    <= byte_count_next;
      running_xor   <= running_xor_next;
      first_payload <= first_payload_next;
      timer_left    <= timer_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  a_arm_loads_timer: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.kind == KIND_ARM |=> phase == PH_HEAD && timer_left == $past(timeout_ticks))
    else $error("arm did not load wait-head phase and timer");

  a_ready_goes_idle: assert property (@(posedge clk) disable iff (rst)
    advance && res.status == ST_READY |=> phase == PH_IDLE && timer_left == 16'd0)
    else $error("ready frame did not return to idle");

  a_nack_holds_check: assert property (@(posedge clk) disable iff (rst)
    advance && res.status == ST_NACK |=> phase == PH_CHECK)
    else $error("nack left the checksum phase");

  a_data_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> frame_size != 8'd0 && byte_count < frame_size)
    else $error("payload phase with inconsistent size or count");

endmodule
`default_nettype wire

>>> test/framed_response_receiver_top_tb.sv
// Testbench: framed response receiver, checked word by word against a frame decode predictor.
`timescale 1ns / 1ps
module framed_response_receiver_top_tb;
  import frr_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 100;
  localparam int PHASE_COUNT  = 6;
  localparam int HOLD_CYCLES  = 200;

  typedef struct packed {
    logic [7:0]  head;
    logic [7:0]  limit;
    logic [7:0]  mask;
    logic [15:0] ticks;
  } rx_cfg_t;

  typedef struct {
    bit        reconfig;
    rx_cfg_t   cfg;
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  // frame state and register copies of the predictor
  phase_t      rx_phase;
  logic [7:0]  rx_size;
  logic [7:0]  rx_count;
  logic [7:0]  rx_xor;
  logic [7:0]  rx_first;
  logic [15:0] rx_timer;
  logic [7:0]  m_head;
  logic [7:0]  m_limit;
  logic [7:0]  m_mask;
  logic [15:0] m_ticks;

  out_word_t pending_results[$];
  dir_row_t  dir_rows[$];
  int        err_count  = 0;
  int        item_count = 0;
  int        quiet_cycles = 0;
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;

  framed_response_receiver_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_word_t decode_expected(in_word_t w);
    out_word_t r;
    logic [7:0] b;
    r = '0;
    r.status = ST_NONE;
    b = w.rx_byte;
    case (kind_t'(w.kind))
      KIND_BYTE: begin
        case (rx_phase)
          PH_HEAD: begin
            if (b != m_head) begin
              r.status = ST_ERROR;
            end else begin
              rx_phase = PH_SIZE;
              r.status = ST_DECODING;
            end
          end
          PH_SIZE: begin
            if (b >= m_limit) begin
              r.status = ST_ERROR;
            end else begin
              rx_size  = b;
              rx_count = 8'd0;
              rx_xor   = b;
              rx_first = 8'd0;
              rx_phase = (b == 8'd0) ? PH_CHECK : PH_DATA;
              r.status = ST_DECODING;
            end
          end
          PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = rx_count;
            if (rx_count == 8'd0) rx_first = b;
            rx_xor   = rx_xor ^ b;
            rx_count = rx_count + 8'd1;
            if (rx_count >= rx_size) rx_phase = PH_CHECK;
            r.status = ST_DECODING;
          end
          PH_CHECK: begin
            if (b != rx_xor) begin
              r.status = ST_ERROR;
            end else if ((rx_first & m_mask) != 8'd0) begin
              // NACK: stay in checksum phase until the timer runs out
              r.status = ST_NACK;
            end else begin
              rx_phase = PH_IDLE;
              rx_timer = 16'd0;
              r.status = ST_READY;
            end
          end
          default: r.status = ST_ERROR;
        endcase
      end
      KIND_ARM: begin
        rx_phase = PH_HEAD;
        rx_timer = m_ticks;
      end
      KIND_TICK: begin
        if (rx_phase != PH_IDLE) begin
          if (rx_timer <= 16'd1) begin
            r.status = (rx_phase == PH_HEAD) ? ST_MISSING : ST_WRONG;
            rx_phase = PH_IDLE;
            rx_timer = 16'd0;
          end else begin
            rx_timer = rx_timer - 16'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t word_row(logic [1:0] k, logic [7:0] b);
    dir_row_t row;
    row = '{reconfig: 1'b0, cfg: '0, word: '{kind: k, rx_byte: b}, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic dir_row_t checked_row(logic [1:0] k, logic [7:0] b, status_t s);
    dir_row_t row;
    row = word_row(k, b);
    row.typed = 1'b1;
    row.want.status = s;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(rx_cfg_t c);
    dir_row_t row;
    row = word_row(KIND_UNUSED, 8'd0);
    row.reconfig = 1'b1;
    row.cfg = c;
    return row;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    out_word_t guess;
    guess = decode_expected(w);
    pending_results.push_back(typed ? want : guess);
    item_count++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_item(logic [1:0] k, logic [7:0] b);
    send_word('{kind: k, rx_byte: b}, 1'b0, '0);
  endtask

  // drain all results, then write every register
  task automatic set_config(rx_cfg_t c);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEAD_MARKER;
    cfg_data  <= {8'd0, c.head};
    @(negedge clk);
    cfg_index <= REG_SIZE_LIMIT;
    cfg_data  <= {8'd0, c.limit};
    @(negedge clk);
    cfg_index <= REG_NACK_MASK;
    cfg_data  <= {8'd0, c.mask};
    @(negedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data  <= c.ticks;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_head  = c.head;
    m_limit = c.limit;
    m_mask  = c.mask;
    m_ticks = c.ticks;
  endtask

  // mostly well-formed frame with random content; now and then a broken step
  task automatic send_frame();
    logic [7:0] size;
    logic [7:0] csum;
    logic [7:0] b;
    int sel;
    int top;
    if ($urandom_range(0, 9) != 0) send_item(KIND_ARM, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    send_item(KIND_BYTE, m_head);
    if ($urandom_range(0, 9) == 0) send_item(KIND_BYTE, 8'($urandom_range(m_limit, 255)));
    top = m_limit - 1;
    sel = $urandom_range(0, 19);
    if (sel == 0) size = 8'(top);
    else if (sel == 1) size = 8'($urandom_range(0, top));
    else size = 8'($urandom_range(0, (top < 6) ? top : 6));
    send_item(KIND_BYTE, size);
    csum = size;
    for (int i = 0; i < size; i++) begin
      b = 8'($urandom_range(0, 255));
      csum = csum ^ b;
      send_item(KIND_BYTE, b);
      if ($urandom_range(0, 15) == 0) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) send_item(KIND_BYTE, csum ^ 8'($urandom_range(1, 255)));
    send_item(KIND_BYTE, csum);
    // run the timer out when that takes only a few ticks
    if (m_ticks <= 16'd64 && $urandom_range(0, 3) == 0) begin
      while (rx_phase != PH_IDLE) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: random short stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result word: status %0d valid %0b byte %02h index %0d",
                   out_data.status, out_data.payload_valid, out_data.payload_byte,
                   out_data.payload_index);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.payload_valid !== want.payload_valid ||
            out_data.payload_byte !== want.payload_byte ||
            out_data.payload_index !== want.payload_index) begin
          err_count++;
          if (err_count <= 10)
            $display("result mismatch: expected %0d/%0b/%02h/%0d, got %0d/%0b/%02h/%0d",
                     want.status, want.payload_valid, want.payload_byte, want.payload_index,
                     out_data.status, out_data.payload_valid, out_data.payload_byte,
                     out_data.payload_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rx_cfg_t c;
    int start;
    bit hold_done;
    hold_done = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_HEAD_MARKER;
    cfg_data  = 16'd0;
    rx_phase  = PH_IDLE;
    rx_size   = 8'd0;
    rx_count  = 8'd0;
    rx_xor    = 8'd0;
    rx_first  = 8'd0;
    rx_timer  = 16'd0;
    m_head    = HEAD_MARKER_RST;
    m_limit   = SIZE_LIMIT_RST;
    m_mask    = NACK_MASK_RST;
    m_ticks   = TIMEOUT_TICKS_RST;

    dir_rows = '{
      checked_row(KIND_TICK,   8'h00, ST_NONE),       // tick while idle
      checked_row(KIND_BYTE,   8'hFF, ST_ERROR),      // byte while idle
      checked_row(KIND_UNUSED, 8'hFF, ST_NONE),
      checked_row(KIND_ARM,    8'h00, ST_NONE),
      checked_row(KIND_BYTE,   8'h00, ST_ERROR),      // wrong head
      checked_row(KIND_BYTE,   HEAD_MARKER_RST, ST_DECODING),
      checked_row(KIND_BYTE,   SIZE_LIMIT_RST, ST_ERROR),   // size at limit
      checked_row(KIND_BYTE,   8'h02, ST_DECODING),
      word_row(KIND_BYTE, 8'h7F),
      word_row(KIND_BYTE, 8'hFF),
      checked_row(KIND_BYTE,   8'h00, ST_ERROR),      // bad checksum
      checked_row(KIND_BYTE,   8'h82, ST_READY),
      checked_row(KIND_ARM,    8'hFF, ST_NONE),
      checked_row(KIND_BYTE,   HEAD_MARKER_RST, ST_DECODING),
      checked_row(KIND_BYTE,   8'h00, ST_DECODING),   // empty frame
      checked_row(KIND_BYTE,   8'h00, ST_READY),
      checked_row(KIND_ARM,    8'h00, ST_NONE),
      checked_row(KIND_BYTE,   HEAD_MARKER_RST, ST_DECODING),
      checked_row(KIND_BYTE,   8'h01, ST_DECODING),
      word_row(KIND_BYTE, 8'h80),
      checked_row(KIND_BYTE,   8'h81, ST_NACK),
      cfg_row('{HEAD_MARKER_RST, SIZE_LIMIT_RST, NACK_MASK_RST, 16'd1}),
      checked_row(KIND_ARM,    8'h00, ST_NONE),
      checked_row(KIND_TICK,   8'h00, ST_MISSING),
      checked_row(KIND_ARM,    8'h00, ST_NONE),
      checked_row(KIND_BYTE,   HEAD_MARKER_RST, ST_DECODING),
      checked_row(KIND_TICK,   8'hFF, ST_WRONG)
    };

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].reconfig) set_config(dir_rows[i].cfg);
      else send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 0) begin
        c = '{8'h00, 8'd1, 8'h00, 16'd1};
      end else if (p == 1) begin
        c = '{8'hFF, 8'd255, 8'hFF, 16'hFFFF};
      end else begin
        c.head  = 8'($urandom_range(0, 255));
        c.limit = 8'($urandom_range(1, 255));
        c.mask  = 8'($urandom_range(0, 255));
        c.ticks = 16'($urandom_range(1, 40));
      end
      set_config(c);
      idle_on = (p != PHASE_COUNT - 1);
      start = item_count;
      while (item_count - start < PHASE_ITEMS) begin
        if (p == 2 && !hold_done && item_count - start > 30) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(0, 4) == 0)
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        else send_frame();
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
